[rtl/rgpsd_pkg.sv]
// Shared constants and types for the RDS group / program service decoder.
`default_nettype none

package rgpsd_pkg;

  // Field widths
  localparam int BlockW  = 16;
  localparam int ErrW    = 3;
  localparam int GroupW  = 4 * BlockW;
  localparam int TotalW  = 32;
  localparam int PtyW    = 5;
  localparam int AgreeW  = 8;
  localparam int FlagW   = 3;

  // Name store
  localparam int NameChars = 8;
  localparam int CharW     = 8;
  localparam int PosW      = $clog2(NameChars);
  localparam int SegW      = PosW - 1;
  localparam int CountW    = 4;
  localparam int NameW     = NameChars * CharW;

  // Configuration
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int PsLimW   = 4;
  localparam logic [CfgIdxW-1:0] RegPsLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPiLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPtyLimit = 2'd2;
  localparam logic [PsLimW-1:0]  PsLimitReset  = 4'd2;
  localparam logic [AgreeW-1:0]  PiLimitReset  = 8'd4;
  localparam logic [AgreeW-1:0]  PtyLimitReset = 8'd4;

  // Block B layout
  localparam int GtypeHi = 15;
  localparam int GtypeLo = 11;
  localparam int TpBit   = 10;
  localparam int PtyHi   = 9;
  localparam int PtyLo   = 5;
  localparam int TaBit   = 4;
  localparam int MsBit   = 3;

  localparam logic [AgreeW-1:0] AgreeMax = 8'hFF;
  localparam logic [CountW-1:0] CountMax = 4'hF;
  localparam logic [ErrW-1:0]   BlocksPerGroup = 3'd4;

  // One character update broadcast along the cell row
  typedef struct packed {
    logic             valid;
    logic [PosW-1:0]  pos;
    logic [CharW-1:0] ch;
  } char_op_t;

  // Neighbor-to-neighbor chain: swap request OR chain, fullness AND chain
  typedef struct packed {
    logic shift;
    logic full;
  } cell_link_t;

endpackage

`default_nettype wire

[rtl/rgpsd_if.sv]
// Valid/ready channel interfaces for RDS groups in and decoded results out.
`default_nettype none

interface rgpsd_in_if import rgpsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] block_a;
  logic [BlockW-1:0] block_b;
  logic [BlockW-1:0] block_c;
  logic [BlockW-1:0] block_d;
  logic [ErrW-1:0]   error_count;

  modport source (output valid, block_a, block_b, block_c, block_d, error_count,
                  input ready);
  modport sink   (input valid, block_a, block_b, block_c, block_d, error_count,
                  output ready);
endinterface

interface rgpsd_out_if import rgpsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] program_id;
  logic [PtyW-1:0]   program_type;
  logic [NameW-1:0]  service_name;
  logic              traffic_program;
  logic              traffic_announce;
  logic              music_speech;
  logic [TotalW-1:0] blocks_valid;
  logic              group_taken;

  modport source (output valid, program_id, program_type, service_name, traffic_program,
                  traffic_announce, music_speech, blocks_valid, group_taken,
                  input ready);
  modport sink   (input valid, program_id, program_type, service_name, traffic_program,
                  traffic_announce, music_speech, blocks_valid, group_taken,
                  output ready);
endinterface

`default_nettype wire

[rtl/rgpsd_front.sv]
// Group filter, valid-block total, PI/PTY agreement voting and flag latch.
`default_nettype none

module rgpsd_front import rgpsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [BlockW-1:0] block_a,
  input  wire logic [BlockW-1:0] block_b,
  input  wire logic [BlockW-1:0] block_c,
  input  wire logic [BlockW-1:0] block_d,
  input  wire logic [ErrW-1:0]   error_count,
  input  wire logic [AgreeW-1:0] pi_limit,
  input  wire logic [AgreeW-1:0] pty_limit,
  output logic                   taken,
  output logic                   name_group,
  output logic [BlockW-1:0]      program_id,
  output logic [PtyW-1:0]        program_type,
  output logic [FlagW-1:0]       flags,
  output logic [TotalW-1:0]      blocks_valid
);

  logic [GroupW-1:0] last_group;
  logic [TotalW-1:0] total;
  logic [BlockW-1:0] pi_cand, pi_shown;
  logic [AgreeW-1:0] pi_agree;
  logic [PtyW-1:0]   pty_cand, pty_shown;
  logic [AgreeW-1:0] pty_agree;
  logic [FlagW-1:0]  flag_bits;

  logic [GroupW-1:0] grp;
  logic              grp_new;
  logic [GtypeHi-GtypeLo:0] gtype;
  logic [PtyW-1:0]   pty_in;
  logic [ErrW-1:0]   add;
  logic [BlockW-1:0] pi_c1, pi_s1, pi_cand_next, pi_shown_next;
  logic [AgreeW-1:0] pi_g1, pi_agree_next;
  logic [AgreeW-1:0] pty_agree_next;
  logic [PtyW-1:0]   pty_shown_next;
  logic [TotalW-1:0] total_next;

  // Agreement count after one vote: restart on a new value, saturate at max.
  function automatic logic [AgreeW-1:0] bump(input logic same, input logic [AgreeW-1:0] agree);
    logic [AgreeW-1:0] r;
    if (!same) r = 8'd1;
    else if (agree == AgreeMax) r = agree;
    else r = agree + 8'd1;
    return r;
  endfunction

  always_comb begin
    grp     = {block_a, block_b, block_c, block_d};
    grp_new = (grp != last_group);
    gtype   = block_b[GtypeHi:GtypeLo];
    pty_in  = block_b[PtyHi:PtyLo];
    taken      = accept && grp_new && (error_count == '0);
    name_group = taken && (gtype[GtypeHi-GtypeLo:1] == '0);

    add        = (error_count < BlocksPerGroup) ? (BlocksPerGroup - error_count) : '0;
    total_next = total + {{(TotalW-ErrW){1'b0}}, add};

    // PI from block A, then block C for B versions
    pi_c1 = block_a;
    pi_g1 = bump(pi_cand == block_a, pi_agree);
    pi_s1 = (pi_g1 > pi_limit) ? block_a : pi_shown;
    if (gtype[0]) begin
      pi_cand_next  = block_c;
      pi_agree_next = bump(pi_c1 == block_c, pi_g1);
      pi_shown_next = (pi_agree_next > pi_limit) ? block_c : pi_s1;
    end else begin
      pi_cand_next  = pi_c1;
      pi_agree_next = pi_g1;
      pi_shown_next = pi_s1;
    end

    pty_agree_next = bump(pty_cand == pty_in, pty_agree);
    pty_shown_next = (pty_agree_next > pty_limit) ? pty_in : pty_shown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_group <= '0;
      total      <= '0;
      pi_cand    <= '0;
      pi_agree   <= '0;
      pi_shown   <= '0;
      pty_cand   <= '0;
      pty_agree  <= '0;
      pty_shown  <= '0;
      flag_bits  <= '0;
    end else begin
      if (accept && grp_new) begin
        last_group <= grp;
        total      <= total_next;
      end
      if (taken) begin
        pi_cand   <= pi_cand_next;
        pi_agree  <= pi_agree_next;
        pi_shown  <= pi_shown_next;
        pty_cand  <= pty_in;
        pty_agree <= pty_agree_next;
        pty_shown <= pty_shown_next;
      end
      if (name_group) begin
        flag_bits <= {block_b[TpBit], block_b[TaBit], block_b[MsBit]};
      end
    end
  end

  assign program_id   = pi_shown;
  assign program_type = pty_shown;
  assign flags        = flag_bits;
  assign blocks_valid = total;

endmodule

`default_nettype wire

[rtl/rgpsd_cell.sv]
// One character position of the name voting store: two candidates and a count.
`default_nettype none

module rgpsd_cell import rgpsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [PosW-1:0]   cell_pos,
  input  wire char_op_t          op,
  input  wire logic [PsLimW-1:0] lim,
  input  wire cell_link_t        link_in,
  output cell_link_t             link_out,
  input  wire logic              shift_all,
  input  wire logic              full_all,
  output logic [CharW-1:0]       shown,
  output logic [CharW-1:0]       shown_next
);

  logic [CharW-1:0]  likely, alternate;
  logic [CountW-1:0] count;

  logic              sel, own_shift;
  logic [CharW-1:0]  likely_mid, alt_mid;
  logic [CountW-1:0] count_mid, count_fin, swap_count;

  always_comb begin
    sel        = op.valid && (op.pos == cell_pos);
    swap_count = (lim == CountMax) ? CountMax : lim + 4'd1;
    likely_mid = likely;
    alt_mid    = alternate;
    count_mid  = count;
    own_shift  = 1'b0;
    if (sel) begin
      if (likely == op.ch) begin
        if (count < lim) begin
          count_mid = count + 4'd1;
        end else begin
          count_mid = lim;
          alt_mid   = op.ch;
        end
      end else if (alternate == op.ch) begin
        // alternate overtakes: swap candidates
        own_shift  = (count >= lim);
        count_mid  = swap_count;
        alt_mid    = likely;
        likely_mid = op.ch;
      end else if (count == '0) begin
        likely_mid = op.ch;
        count_mid  = 4'd1;
      end else begin
        alt_mid = op.ch;
      end
    end
    count_fin = (shift_all && (count_mid > 4'd1)) ? count_mid - 4'd1 : count_mid;

    link_out.shift = link_in.shift | own_shift;
    link_out.full  = link_in.full & (count_fin >= lim);
    shown_next     = full_all ? likely_mid : shown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      likely    <= '0;
      alternate <= '0;
      count     <= '0;
      shown     <= '0;
    end else begin
      likely    <= likely_mid;
      alternate <= alt_mid;
      count     <= count_fin;
      shown     <= shown_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rds_group_ps_decoder.sv]
// Top level: RDS group decoder for program id, type, flags and service name.
// A transferred group sets pend, then the second character step loads the
//   output register; no new group is taken meanwhile. The name cell row
//   applies the two characters of a group one after the other, one per cycle.
// A full output register stalls the second character step and thus the input.
// Synchronous active-high rst clears control and voting state; limits go to 2/4/4.
`default_nettype none

module rds_group_ps_decoder import rgpsd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  rgpsd_in_if.sink                 groups,
  rgpsd_out_if.source              results,
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic [PsLimW-1:0] ps_limit;
  logic [AgreeW-1:0] pi_limit, pty_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps_limit  <= PsLimitReset;
      pi_limit  <= PiLimitReset;
      pty_limit <= PtyLimitReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegPsLimit:  ps_limit  <= cfg_data[PsLimW-1:0];
        RegPiLimit:  pi_limit  <= cfg_data;
        RegPtyLimit: pty_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake. pend marks the second character step of the last transfer.
  logic pend, pend_name, pend_taken;
  logic [SegW-1:0]  pend_seg;
  logic [CharW-1:0] pend_ch;
  logic accept, can_load, finish;
  logic out_valid;

  assign groups.ready = !pend;
  assign accept       = groups.valid && !pend;
  assign can_load     = !out_valid || results.ready;
  assign finish       = pend && can_load;

  // Group-level work: filter, totals, PI/PTY votes, flags
  logic              taken, name_group;
  logic [BlockW-1:0] program_id;
  logic [PtyW-1:0]   program_type;
  logic [FlagW-1:0]  flags;
  logic [TotalW-1:0] blocks_valid;

  rgpsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .block_a      (groups.block_a),
    .block_b      (groups.block_b),
    .block_c      (groups.block_c),
    .block_d      (groups.block_d),
    .error_count  (groups.error_count),
    .pi_limit     (pi_limit),
    .pty_limit    (pty_limit),
    .taken        (taken),
    .name_group   (name_group),
    .program_id   (program_id),
    .program_type (program_type),
    .flags        (flags),
    .blocks_valid (blocks_valid)
  );

  // Character op: high byte on the transfer cycle, low byte in the pend step.
  char_op_t cell_op;

  always_comb begin
    if (pend) begin
      cell_op.valid = pend_name && can_load;
      cell_op.pos   = {pend_seg, 1'b1};
      cell_op.ch    = pend_ch;
    end else begin
      cell_op.valid = name_group;
      cell_op.pos   = {groups.block_b[SegW-1:0], 1'b0};
      cell_op.ch    = groups.block_d[BlockW-1:CharW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (finish) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_name  <= name_group;
      pend_taken <= taken;
      pend_seg   <= groups.block_b[SegW-1:0];
      pend_ch    <= groups.block_d[CharW-1:0];
    end
  end

  // Name cell row. Swap requests ripple as an OR chain and counts-at-limit as
  // an AND chain; the chain ends are broadcast back to every cell.
  cell_link_t       link [NameChars+1];
  logic             shift_all, full_all;
  logic [CharW-1:0] shown_arr [NameChars];
  logic [CharW-1:0] shown_next_arr [NameChars];
  logic [NameW-1:0] name_now, name_next;

  assign link[0].shift = 1'b0;
  assign link[0].full  = 1'b1;
  assign shift_all     = cell_op.valid && link[NameChars].shift;
  assign full_all      = cell_op.valid && link[NameChars].full;

  for (genvar i = 0; i < NameChars; i++) begin : g_cell
    rgpsd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_pos   (PosW'(i)),
      .op         (cell_op),
      .lim        (ps_limit),
      .link_in    (link[i]),
      .link_out   (link[i+1]),
      .shift_all  (shift_all),
      .full_all   (full_all),
      .shown      (shown_arr[i]),
      .shown_next (shown_next_arr[i])
    );
  end

  // character 0 in the top byte
  always_comb begin
    for (int i = 0; i < NameChars; i++) begin
      name_now[(NameChars-1-i)*CharW +: CharW]  = shown_arr[i];
      name_next[(NameChars-1-i)*CharW +: CharW] = shown_next_arr[i];
    end
  end

  // Output register, loaded when the second character step completes
  logic [BlockW-1:0] res_pi;
  logic [PtyW-1:0]   res_pty;
  logic [NameW-1:0]  res_name;
  logic [FlagW-1:0]  res_flags;
  logic [TotalW-1:0] res_total;
  logic              res_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_pi    <= program_id;
      res_pty   <= program_type;
      res_name  <= name_next;
      res_flags <= flags;
      res_total <= blocks_valid;
      res_taken <= pend_taken;
    end
  end

  assign results.valid            = out_valid;
  assign results.program_id       = res_pi;
  assign results.program_type     = res_pty;
  assign results.service_name     = res_name;
  assign results.traffic_program  = res_flags[2];
  assign results.traffic_announce = res_flags[1];
  assign results.music_speech     = res_flags[0];
  assign results.blocks_valid     = res_total;
  assign results.group_taken      = res_taken;

  // Checks
  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend)
    else $error("transfer did not start the second character step");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && !pend))
    else $error("second character step did not load the output register");

  a_name_quiet: assert property (@(posedge clk) disable iff (rst)
    !cell_op.valid |=> $stable(name_now))
    else $error("published name changed without a character update");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for rds_group_ps_decoder, scored against a cycle-free decode model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgpsd_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int CycleLimit   = 200_000;
  localparam int SettleCycles = 4;
  localparam int PrintCap     = 100;

  // Group type field codes (block B 15:11, bit 11 set = B version)
  localparam int GtypeW = GtypeHi - GtypeLo + 1;
  localparam logic [GtypeW-1:0] Grp0A = 5'd0;
  localparam logic [GtypeW-1:0] Grp0B = 5'd1;
  localparam logic [GtypeW-1:0] Grp2A = 5'd4;

  localparam logic [NameW-1:0] DemoName = "RADIO  X";

  typedef struct packed {
    logic [BlockW-1:0] a;
    logic [BlockW-1:0] b;
    logic [BlockW-1:0] c;
    logic [BlockW-1:0] d;
    logic [ErrW-1:0]   errs;
  } rds_group_t;

  typedef struct packed {
    logic [BlockW-1:0] pi;
    logic [PtyW-1:0]   pty;
    logic [NameW-1:0]  name;
    logic              tp;
    logic              ta;
    logic              ms;
    logic [TotalW-1:0] total;
    logic              taken;
  } decode_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  rgpsd_in_if  group_ch ();
  rgpsd_out_if result_ch ();

  rds_group_ps_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .groups    (group_ch),
    .results   (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decode model: our own copy of every piece of decoder state
  // ---------------------------------------------------------------------------
  logic [PsLimW-1:0] lim_ps;
  logic [AgreeW-1:0] lim_pi;
  logic [AgreeW-1:0] lim_pty;

  logic [GroupW-1:0] prev_group;
  logic [TotalW-1:0] blk_total;
  logic [BlockW-1:0] pi_cand, pi_pub;
  logic [AgreeW-1:0] pi_cnt;
  logic [PtyW-1:0]   pty_cand, pty_pub;
  logic [AgreeW-1:0] pty_cnt;
  logic [CharW-1:0]  ch_best [NameChars];
  logic [CharW-1:0]  ch_alt  [NameChars];
  logic [CountW-1:0] ch_cnt  [NameChars];
  logic [CharW-1:0]  ch_pub  [NameChars];
  logic [FlagW-1:0]  flags;  // {TP, TA, MS}

  function automatic void clear_model();
    lim_ps     = PsLimitReset;
    lim_pi     = PiLimitReset;
    lim_pty    = PtyLimitReset;
    prev_group = '0;
    blk_total  = '0;
    pi_cand    = '0;
    pi_cnt     = '0;
    pi_pub     = '0;
    pty_cand   = '0;
    pty_cnt    = '0;
    pty_pub    = '0;
    flags      = '0;
    for (int i = 0; i < NameChars; i++) begin
      ch_best[i] = '0;
      ch_alt[i]  = '0;
      ch_cnt[i]  = '0;
      ch_pub[i]  = '0;
    end
  endfunction

  // Agreement counters: restart at 1 on a new value, saturate at the top
  function automatic void agree_pi(logic [BlockW-1:0] v);
    if (pi_cand != v) begin
      pi_cand = v;
      pi_cnt  = 8'd1;
    end else if (pi_cnt != AgreeMax) begin
      pi_cnt++;
    end
    if (pi_cnt > lim_pi) pi_pub = pi_cand;
  endfunction

  function automatic void agree_pty(logic [PtyW-1:0] v);
    if (pty_cand != v) begin
      pty_cand = v;
      pty_cnt  = 8'd1;
    end else if (pty_cnt != AgreeMax) begin
      pty_cnt++;
    end
    if (pty_cnt > lim_pty) pty_pub = pty_cand;
  endfunction

  // Two-candidate vote on one name position. Promoting the alternate over a
  // settled character ages every position above one by one.
  function automatic void tally_char(int pos, logic [CharW-1:0] ch);
    logic swap;
    logic full;
    swap = 1'b0;
    full = 1'b1;
    if (ch_best[pos] == ch) begin
      if (ch_cnt[pos] < lim_ps) begin
        ch_cnt[pos]++;
      end else begin
        ch_cnt[pos] = lim_ps;
        ch_alt[pos] = ch;
      end
    end else if (ch_alt[pos] == ch) begin
      if (ch_cnt[pos] >= lim_ps) swap = 1'b1;
      ch_cnt[pos]  = (lim_ps == CountMax) ? CountMax : CountW'(lim_ps + 1);
      ch_alt[pos]  = ch_best[pos];
      ch_best[pos] = ch;
    end else if (ch_cnt[pos] == '0) begin
      ch_best[pos] = ch;
      ch_cnt[pos]  = 4'd1;
    end else begin
      ch_alt[pos] = ch;
    end
    if (swap) begin
      for (int i = 0; i < NameChars; i++)
        if (ch_cnt[i] > 4'd1) ch_cnt[i]--;
    end
    for (int i = 0; i < NameChars; i++)
      if (ch_cnt[i] < lim_ps) full = 1'b0;
    if (full) begin
      for (int i = 0; i < NameChars; i++) ch_pub[i] = ch_best[i];
    end
  endfunction

  // Applies one transferred group and returns what the output should show.
  function automatic decode_t predict_decode(rds_group_t g);
    decode_t           r;
    logic [GroupW-1:0] blocks;
    logic [GtypeW-1:0] gtype;
    int                seg;
    blocks  = {g.a, g.b, g.c, g.d};
    gtype   = g.b[GtypeHi:GtypeLo];
    r.taken = 1'b0;
    // A repeat is judged on the blocks alone, whatever the error count says
    if (blocks != prev_group) begin
      prev_group = blocks;
      if (g.errs < BlocksPerGroup) blk_total += TotalW'(BlocksPerGroup - g.errs);
      if (g.errs == '0) begin
        r.taken = 1'b1;
        agree_pi(g.a);
        if (gtype[0]) agree_pi(g.c);
        agree_pty(g.b[PtyHi:PtyLo]);
        if (gtype == Grp0A || gtype == Grp0B) begin
          flags = {g.b[TpBit], g.b[TaBit], g.b[MsBit]};
          seg   = int'(g.b[SegW-1:0]);
          tally_char(2 * seg, g.d[BlockW-1:CharW]);
          tally_char(2 * seg + 1, g.d[CharW-1:0]);
        end
      end
    end
    r.pi    = pi_pub;
    r.pty   = pty_pub;
    for (int i = 0; i < NameChars; i++) r.name[NameW-1-CharW*i -: CharW] = ch_pub[i];
    r.tp    = flags[2];
    r.ta    = flags[1];
    r.ms    = flags[0];
    r.total = blk_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: a simulated station plus noise, repeats and errored groups
  // ---------------------------------------------------------------------------
  rds_group_t groups_to_send [$];
  decode_t    pending_decodes [$];

  int noise_pct, churn_pct, err_pct, rep_pct;
  int send_idle_pct, recv_idle_pct;

  logic [BlockW-1:0] stn_pi;
  logic [PtyW-1:0]   stn_pty;
  logic [CharW-1:0]  stn_name [NameChars];
  logic [SegW-1:0]   stn_seg;
  rds_group_t        last_made;

  function automatic logic [BlockW-1:0] block_b(logic [GtypeW-1:0] gtype, logic tp,
                                                logic [PtyW-1:0] pty, logic ta, logic ms,
                                                logic [SegW-1:0] seg);
    return {gtype, tp, pty, ta, ms, 1'b0, seg};
  endfunction

  function automatic void queue_group(logic [BlockW-1:0] a, logic [BlockW-1:0] b,
                                      logic [BlockW-1:0] c, logic [BlockW-1:0] d,
                                      logic [ErrW-1:0] errs);
    last_made = '{a: a, b: b, c: c, d: d, errs: errs};
    groups_to_send.push_back(last_made);
  endfunction

  function automatic rds_group_t make_group();
    rds_group_t        g;
    logic [GtypeW-1:0] gtype;
    logic [SegW-1:0]   seg;
    int                roll;
    roll = $urandom_range(99);
    if (roll < rep_pct) begin
      // Same blocks as last time: must be dropped whatever the error count
      g      = last_made;
      g.errs = ErrW'($urandom);
    end else if (roll < rep_pct + noise_pct) begin
      g.a    = BlockW'($urandom);
      g.b    = BlockW'($urandom);
      g.c    = BlockW'($urandom);
      g.d    = BlockW'($urandom);
      g.errs = ErrW'($urandom);
    end else begin
      // Station drift; name letters come from a tiny alphabet so they flip back
      if ($urandom_range(99) < churn_pct) begin
        case ($urandom_range(2))
          0: stn_pi = BlockW'($urandom);
          1: stn_pty = PtyW'($urandom);
          default: stn_name[$urandom_range(NameChars-1)] = CharW'($urandom_range(8'h41, 8'h44));
        endcase
      end
      if ($urandom_range(99) < 60) begin
        gtype   = $urandom_range(1) ? Grp0B : Grp0A;
        seg     = stn_seg;
        stn_seg = stn_seg + 1'b1;
        g.d     = {stn_name[2*seg], stn_name[2*seg+1]};
        if ($urandom_range(99) < 4) g.d[$urandom_range(1)*CharW +: CharW] = CharW'($urandom);
        g.b     = block_b(gtype, 1'($urandom), stn_pty, 1'($urandom), 1'($urandom), seg);
        g.b[2]  = 1'($urandom);
      end else begin
        gtype = GtypeW'($urandom_range(2, 31));
        g.d   = BlockW'($urandom);
        g.b   = {gtype, 1'($urandom), stn_pty, 5'($urandom)};
      end
      g.a    = stn_pi;
      g.c    = (gtype[0] && $urandom_range(99) >= churn_pct) ? stn_pi : BlockW'($urandom);
      g.errs = ($urandom_range(99) < err_pct) ? ErrW'($urandom_range(1, 7)) : '0;
    end
    last_made = g;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Group driver: presents the head of the queue, pops it on transfer
  // ---------------------------------------------------------------------------
  bit group_sent;

  always @(posedge clk) begin : group_accept
    if (!rst && group_ch.valid && group_ch.ready) begin
      pending_decodes.push_back(predict_decode('{a: group_ch.block_a, b: group_ch.block_b,
                                                 c: group_ch.block_c, d: group_ch.block_d,
                                                 errs: group_ch.error_count}));
      void'(groups_to_send.pop_front());
      group_sent = 1'b1;
    end
  end

  always @(negedge clk) begin : group_drive
    if (rst) begin
      group_ch.valid <= 1'b0;
    end else if (!group_ch.valid || group_sent) begin
      group_sent = 1'b0;
      if (groups_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        group_ch.valid       <= 1'b1;
        group_ch.block_a     <= groups_to_send[0].a;
        group_ch.block_b     <= groups_to_send[0].b;
        group_ch.block_c     <= groups_to_send[0].c;
        group_ch.block_d     <= groups_to_send[0].d;
        group_ch.error_count <= groups_to_send[0].errs;
      end else begin
        group_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin : result_stall
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every transfer is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  int mismatches;
  int results_seen;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("%0t ns: result %0d mismatch: %s", $time, results_seen, msg);
  endtask

  always @(posedge clk) begin : result_check
    decode_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("result with no group outstanding");
      end else begin
        want = pending_decodes.pop_front();
        if (result_ch.program_id !== want.pi)
          report_mismatch($sformatf("program_id %h, want %h", result_ch.program_id, want.pi));
        if (result_ch.program_type !== want.pty)
          report_mismatch($sformatf("program_type %h, want %h", result_ch.program_type,
                                    want.pty));
        if (result_ch.service_name !== want.name)
          report_mismatch($sformatf("service_name %h, want %h", result_ch.service_name,
                                    want.name));
        if (result_ch.traffic_program !== want.tp)
          report_mismatch($sformatf("traffic_program %b, want %b", result_ch.traffic_program,
                                    want.tp));
        if (result_ch.traffic_announce !== want.ta)
          report_mismatch($sformatf("traffic_announce %b, want %b", result_ch.traffic_announce,
                                    want.ta));
        if (result_ch.music_speech !== want.ms)
          report_mismatch($sformatf("music_speech %b, want %b", result_ch.music_speech,
                                    want.ms));
        if (result_ch.blocks_valid !== want.total)
          report_mismatch($sformatf("blocks_valid %0d, want %0d", result_ch.blocks_valid,
                                    want.total));
        if (result_ch.group_taken !== want.taken)
          report_mismatch($sformatf("group_taken %b, want %b", result_ch.group_taken,
                                    want.taken));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Limits only move while the decoder is idle; the model copy follows once
  // the last write edge has passed.
  task automatic set_limits(logic [PsLimW-1:0] ps, logic [AgreeW-1:0] pi,
                            logic [AgreeW-1:0] pty);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= RegPsLimit;
    cfg_data  <= CfgDataW'(ps);
    @(negedge clk);
    cfg_index <= RegPiLimit;
    cfg_data  <= pi;
    @(negedge clk);
    cfg_index <= RegPtyLimit;
    cfg_data  <= pty;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    lim_ps  = ps;
    lim_pi  = pi;
    lim_pty = pty;
  endtask

  // Wait until every queued group is sent and every result is back.
  task automatic drain();
    do @(posedge clk);
    while (groups_to_send.size() != 0 || pending_decodes.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) groups_to_send.push_back(make_group());
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_index            = RegPsLimit;
    cfg_data             = '0;
    group_ch.valid       = 1'b0;
    group_ch.block_a     = '0;
    group_ch.block_b     = '0;
    group_ch.block_c     = '0;
    group_ch.block_d     = '0;
    group_ch.error_count = '0;
    result_ch.ready      = 1'b0;
    mismatches           = 0;
    results_seen         = 0;
    clear_model();

    stn_pi  = BlockW'($urandom);
    stn_pty = PtyW'($urandom);
    stn_seg = '0;
    for (int i = 0; i < NameChars; i++) stn_name[i] = CharW'($urandom_range(8'h41, 8'h44));

    // Sender lazy now and then, receiver mostly stalled
    send_idle_pct = 21;
    recv_idle_pct = 69;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset limits (ps 2, pi 4, pty 4)
    // All-zero group straight after reset equals the cleared history: ignored
    queue_group('0, '0, '0, '0, '0);
    // Every bit set: type 15B, votes PI from blocks A and C
    queue_group('1, '1, '1, '1, '0);
    queue_group('1, '1, '1, '1, '0);
    // Still a repeat even with the worst error count
    queue_group('1, '1, '1, '1, 3'd7);
    // Four or more errors: no blocks counted
    queue_group(16'h1234, block_b(Grp2A, 1'b0, 5'd3, 1'b0, 1'b0, 2'd0), '0, '0, 3'd4);
    queue_group(16'h1234, block_b(Grp2A, 1'b0, 5'd3, 1'b0, 1'b0, 2'd1), '0, '0, 3'd3);
    queue_group(16'h1234, block_b(Grp2A, 1'b0, 5'd3, 1'b0, 1'b0, 2'd2), '0, '0, 3'd1);
    // 0A with every flag set, then 0B with none and PI repeated in block C
    queue_group(16'h5A5A, block_b(Grp0A, 1'b1, 5'd9, 1'b1, 1'b1, 2'd0), '0, "RA", '0);
    queue_group(16'h5A5A, block_b(Grp0B, 1'b0, 5'd9, 1'b0, 1'b0, 2'd3), 16'h5A5A, " X", '0);
    // Two full passes over the name: every position reaches the limit
    for (int r = 0; r < 2; r++)
      for (int s = 0; s < 4; s++)
        queue_group(16'h5A5A, block_b(Grp0A, 1'b0, 5'd9, 1'b1, 1'b0, SegW'(s)), 16'hC0DE,
                    DemoName[NameW-1-BlockW*s -: BlockW], '0);
    // New letters at segment 0 twice: alternate, then promotion that ages the row
    queue_group(16'h5A5A, block_b(Grp0A, 1'b0, 5'd9, 1'b0, 1'b0, 2'd0), 16'hC0DE, "QA", '0);
    queue_group(16'h5A5A, block_b(Grp0A, 1'b0, 5'd9, 1'b1, 1'b0, 2'd0), 16'hC0DE, "QA", '0);
    // Non-name group type: PI and PTY only, flags untouched
    queue_group('1, block_b(Grp2A, 1'b1, 5'd31, 1'b1, 1'b1, 2'd3), '0, '1, '0);
    // All-zero group again, now a fresh 0A carrying two NUL characters
    queue_group('0, '0, '0, '0, '0);
    drain();

    // Phase 1: lowest PI and PTY limits, ps limit 1, busy station with noise
    noise_pct = 15;
    churn_pct = 5;
    err_pct   = 12;
    rep_pct   = 8;
    set_limits(4'd1, 8'd0, 8'd0);
    queue_random(300);
    drain();

    // Phase 2: high limits, steady station long enough to saturate the
    // agreement counters; roles of the two stalls swapped
    send_idle_pct = 69;
    recv_idle_pct = 21;
    noise_pct     = 0;
    churn_pct     = 0;
    err_pct       = 4;
    rep_pct       = 4;
    set_limits(4'd14, 8'd254, 8'd254);
    queue_random(340);
    drain();

    // Phase 3: mid limits at full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    noise_pct     = 10;
    churn_pct     = 3;
    err_pct       = 10;
    rep_pct       = 6;
    set_limits(4'd3, 8'd2, 8'd3);
    queue_random(210);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
